// File: hw/rtl/bai_pkg.sv
package bai_pkg;

	localparam int NUM_BANKS_DEF = 36;

	// region codes of an address record
	localparam logic [2:0] REGION_ERAS_UNB = 3'd0;
	localparam logic [2:0] REGION_ERAS_BNK = 3'd1;
	localparam logic [2:0] REGION_FIX_BNK  = 3'd2;
	localparam logic [2:0] REGION_FIX_UNB  = 3'd3;

	// request kinds carried on tuser
	localparam logic REQ_INCREMENT = 1'b0;
	localparam logic REQ_READ_COUNT = 1'b1;

	localparam int VALUE_W = 17;
	localparam int SREG_W = 12;
	localparam int FBANK_W = 6;
	localparam int EBANK_W = 3;
	localparam int COUNT_W = 16;
	localparam int ADDED_W = 12;
	localparam int IN_TDATA_W = 64;
	localparam int OUT_TDATA_W = 80;

	typedef struct packed {
		logic                 invalid;
		logic                 constant;
		logic [VALUE_W-1:0]   value;
		logic [2:0]           region;
		logic [EBANK_W-1:0]   ebank;
		logic [FBANK_W-1:0]   fbank;
		logic                 sup;
		logic [SREG_W-1:0]    sreg;
		logic                 overflow;
	} record_t;

endpackage

// File: hw/rtl/banked_address_increment.sv
// pipeline: a word accepted on the slave side passes through two pipeline
// stages and the output register before it is presented on the master side
// throughput: one word per cycle while m_tready does not stall the output; the
// bank counter read-modify-write is forwarded between back-to-back words hitting the same bank
// reset: arst_n clears control, block1 mode and the per-bank valid bits, so
// all counters read zero right after reset with no clearing pass
module banked_address_increment
	import bai_pkg::*;
#(
	parameter int NUM_BANKS = NUM_BANKS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic                   cfg_wdata,   // block1_mode
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// in_invalid, in_constant, in_value[16:0], in_region[2:0], in_ebank[2:0],
	// in_fbank[5:0], in_super, in_sreg[11:0], in_overflow, increment[15:0],
	// pure_instruction, zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,     // req_type
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_invalid, out_constant, out_value[16:0], out_region[2:0],
	// out_ebank[2:0], out_fbank[5:0], out_super, out_sreg[11:0], out_overflow,
	// overflow_words_added[11:0], bank_count[15:0], zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(NUM_BANKS);
	localparam logic [FBANK_W:0] NB_EXT = (FBANK_W+1)'(NUM_BANKS);
	localparam logic [FBANK_W:0] FB_MAX = (FBANK_W+1)'(NUM_BANKS - 1);

	logic            block1_q;
	logic            advance;

	// ---------------- input decode ----------------
	record_t         rec_in;
	logic [15:0]     inc_raw;
	logic [15:0]     inc_mag;
	logic            conv_ok;
	logic            pass_in;
	record_t         rec_d;

	// ---------------- stage 1 ----------------
	logic            v_s1;
	logic            rd_s1;
	logic            pass_s1;
	record_t         rec_s1;
	logic signed [3:0]  bstep_s1;
	logic signed [12:0] sstep_s1;
	logic            pure_s1;

	logic signed [13:0] sum;
	logic signed [4:0]  eb_sum;
	logic signed [7:0]  fb_sum;
	logic [EBANK_W-1:0] eb_adj;
	logic [FBANK_W-1:0] fb_adj;
	logic [2:0]      reg_adj;
	logic            sup_adj;
	logic            win_ok;
	logic [SREG_W-1:0] lo;
	logic [SREG_W-1:0] hi;
	logic [SREG_W-1:0] sreg_new;
	logic            ovf_new;
	logic            cnt_new;
	logic [ADDED_W-1:0] add_new;
	logic            recalc_new;
	record_t         rec_out1;
	logic [IDX_W-1:0] raddr;

	// ---------------- stage 2 ----------------
	logic            v_s2;
	logic            rd_s2;
	logic            rdok_s2;
	record_t         rec_s2;
	logic            cnt_s2;
	logic [ADDED_W-1:0] add_s2;
	logic            recalc_s2;
	logic [IDX_W-1:0] idx_s2;
	logic            fwd_s2;
	logic [COUNT_W-1:0] fwd_data_s2;
	logic            vld_s2;

	logic [COUNT_W-1:0] rdata;
	logic [COUNT_W-1:0] cnt_eff;
	logic [COUNT_W-1:0] cnt_upd;
	logic            we;
	logic            fwd_hit;
	logic [17:0]     nv;
	logic [VALUE_W-1:0] value_fin;
	logic [NUM_BANKS-1:0] valid_q;

	// ---------------- output register ----------------
	logic            ov_q;
	record_t         orec_q;
	logic [ADDED_W-1:0] added_q;
	logic [COUNT_W-1:0] count_q;

	assign advance  = !ov_q || m_tready;
	assign s_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block1_q <= 1'b0;
		end else if (cfg_wen) begin
			block1_q <= cfg_wdata;
		end
	end

	// input unpacking, constant conversion and increment magnitude
	always_comb begin
		rec_in.invalid  = s_tdata[0];
		rec_in.constant = s_tdata[1];
		rec_in.value    = s_tdata[18:2];
		rec_in.region   = s_tdata[21:19];
		rec_in.ebank    = s_tdata[24:22];
		rec_in.fbank    = s_tdata[30:25];
		rec_in.sup      = s_tdata[31];
		rec_in.sreg     = s_tdata[43:32];
		rec_in.overflow = s_tdata[44];
		inc_raw         = s_tdata[60:45];
		inc_mag         = inc_raw[15] ? (16'd0 - inc_raw) : inc_raw;

		// small non-negative constant below 01400 turns into erasable unbanked
		conv_ok = !rec_in.value[16] && (rec_in.value < VALUE_W'(12'o1400));
		pass_in = rec_in.invalid || (rec_in.constant && !conv_ok);

		// a count read keeps its bank field as given
		rec_d = rec_in;
		if (s_tuser == REQ_INCREMENT && !rec_in.invalid && rec_in.constant && conv_ok) begin
			rec_d.constant = 1'b0;
			rec_d.region   = REGION_ERAS_UNB;
			rec_d.ebank    = '0;
			rec_d.fbank    = '0;
			rec_d.sup      = 1'b0;
			rec_d.sreg     = rec_in.value[SREG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_s1    <= s_tuser;
			pass_s1  <= pass_in;
			rec_s1   <= rec_d;
			pure_s1  <= s_tdata[61];
			bstep_s1 <= inc_raw[15] ? -$signed({1'b0, inc_mag[14:12]})
			                        : $signed({1'b0, inc_mag[14:12]});
			sstep_s1 <= inc_raw[15] ? -$signed({1'b0, inc_mag[11:0]})
			                        : $signed({1'b0, inc_mag[11:0]});
		end
	end

	// stage 1: bank saturation, window clamp, counter address
	always_comb begin
		sum    = $signed({2'b00, rec_s1.sreg}) + 14'(sstep_s1);
		eb_sum = $signed({2'b00, rec_s1.ebank}) + 5'(bstep_s1);
		fb_sum = $signed({2'b00, rec_s1.fbank}) + 8'(bstep_s1);

		reg_adj = rec_s1.region;
		eb_adj  = rec_s1.ebank;
		fb_adj  = rec_s1.fbank;
		sup_adj = rec_s1.sup;

		if (rec_s1.region == REGION_ERAS_BNK) begin
			if (eb_sum < 0) begin
				eb_adj = '0;
			end else if (eb_sum > 5'sd7) begin
				eb_adj = 3'd7;
			end else begin
				eb_adj = eb_sum[EBANK_W-1:0];
			end
		end else if (rec_s1.region == REGION_FIX_BNK) begin
			if (fb_sum < 0) begin
				fb_adj = '0;
			end else if (fb_sum > $signed({1'b0, FB_MAX})) begin
				fb_adj = FB_MAX[FBANK_W-1:0];
			end else begin
				fb_adj = fb_sum[FBANK_W-1:0];
			end
		end

		// fixed memory stepped into bank zero becomes erasable unbanked
		if ((rec_s1.region == REGION_FIX_BNK || rec_s1.region == REGION_FIX_UNB) &&
		    bstep_s1 != 0 && fb_adj == '0) begin
			reg_adj = REGION_ERAS_UNB;
			eb_adj  = '0;
			fb_adj  = '0;
			sup_adj = 1'b0;
		end

		win_ok = 1'b1;
		lo     = '0;
		hi     = '0;
		case (reg_adj)
			REGION_ERAS_UNB: begin
				hi = block1_q ? 12'o1777 : 12'o1377;
			end
			REGION_ERAS_BNK: begin
				win_ok = !block1_q;
				lo     = 12'o1400;
				hi     = 12'o1777;
			end
			REGION_FIX_BNK: begin
				lo = block1_q ? 12'o6000 : 12'o2000;
				hi = block1_q ? 12'o7777 : 12'o3777;
			end
			REGION_FIX_UNB: begin
				lo = block1_q ? 12'o2000 : 12'o4000;
				hi = 12'o7777;
			end
			default: begin
				win_ok = 1'b0;
			end
		endcase

		sreg_new = sum[SREG_W-1:0];
		ovf_new  = rec_s1.overflow;
		cnt_new  = 1'b0;
		add_new  = '0;
		if (win_ok) begin
			if (sum < $signed({2'b00, lo})) begin
				ovf_new  = 1'b1;
				sreg_new = lo;
			end else if (sum > $signed({2'b00, hi})) begin
				ovf_new  = 1'b1;
				sreg_new = hi;
				// pure instruction running a few words past a fixed bank's top
				if (pure_s1 && reg_adj == REGION_FIX_BNK && sstep_s1 > 0 &&
				    sstep_s1 < 13'sd6 && {1'b0, fb_adj} < NB_EXT) begin
					cnt_new = 1'b1;
					add_new = ADDED_W'(sum - $signed({2'b00, hi}));
				end
			end
		end
		recalc_new = win_ok && !ovf_new;

		rec_out1          = rec_s1;
		rec_out1.invalid  = !win_ok;
		rec_out1.region   = reg_adj;
		rec_out1.ebank    = eb_adj;
		rec_out1.fbank    = fb_adj;
		rec_out1.sup      = sup_adj;
		rec_out1.sreg     = sreg_new;
		rec_out1.overflow = ovf_new;

		if (pass_s1) begin
			rec_out1   = rec_s1;
			cnt_new    = 1'b0;
			recalc_new = 1'b0;
		end

		raddr = rd_s1 ? rec_s1.fbank[IDX_W-1:0] : fb_adj[IDX_W-1:0];
	end

	// stage 2: counter read-modify-write
	assign cnt_eff = fwd_s2 ? fwd_data_s2 : (vld_s2 ? rdata : '0);
	assign cnt_upd = cnt_eff + COUNT_W'(add_s2);
	assign we      = advance && v_s2 && !rd_s2 && cnt_s2;
	assign fwd_hit = we && (idx_s2 == raddr);

	bai_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(NUM_BANKS)
	) u_count_ram (
		.clk  (clk),
		.we   (we),
		.waddr(idx_s2),
		.wdata(cnt_upd),
		.re   (advance),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			valid_q <= '0;
		end else begin
			if (advance) begin
				v_s2 <= v_s1;
			end
			if (we) begin
				valid_q[idx_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_s2       <= rd_s1;
			rdok_s2     <= {1'b0, rec_s1.fbank} < NB_EXT;
			rec_s2      <= rec_out1;
			cnt_s2      <= cnt_new;
			add_s2      <= add_new;
			recalc_s2   <= recalc_new;
			idx_s2      <= raddr;
			fwd_s2      <= fwd_hit;
			fwd_data_s2 <= cnt_upd;
			vld_s2      <= valid_q[raddr] | fwd_hit;
		end
	end

	// pseudo-address recomputation
	always_comb begin
		case (rec_s2.region)
			REGION_ERAS_BNK: begin
				nv = 18'(rec_s2.sreg) - 18'(12'o1400) + {7'b0, rec_s2.ebank, 8'b0};
			end
			REGION_FIX_BNK: begin
				nv = 18'(rec_s2.sreg) + 18'(12'o6000) + {2'b0, rec_s2.fbank, 10'b0};
				if (rec_s2.sup && rec_s2.fbank >= 6'o30) begin
					nv = nv + 18'h2000;
				end
			end
			default: begin
				nv = 18'(rec_s2.sreg);
			end
		endcase
		if (!recalc_s2) begin
			value_fin = rec_s2.value;
		end else if (nv > 18'd65535) begin
			value_fin = 17'd65535;
		end else begin
			value_fin = nv[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (advance) begin
			ov_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (rd_s2 == REQ_READ_COUNT) begin
				orec_q  <= '0;
				added_q <= '0;
				count_q <= rdok_s2 ? cnt_eff : '0;
			end else begin
				orec_q       <= rec_s2;
				orec_q.value <= value_fin;
				added_q      <= cnt_s2 ? add_s2 : '0;
				count_q      <= '0;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {7'b0, count_q, added_q, orec_q.overflow, orec_q.sreg, orec_q.sup,
	                   orec_q.fbank, orec_q.ebank, orec_q.region, orec_q.value,
	                   orec_q.constant, orec_q.invalid};

endmodule

// File: hw/rtl/bai_ram.sv
module bai_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
